>>> design/svd_pkg.sv
// Shared types and constants for the signed varint decoder.
// Depends on nothing; every other file of the block imports it.
package svd_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 3;

  // Fields of one input byte
  localparam int unsigned SignBit   = 6;
  localparam int unsigned ContBit   = 7;
  localparam logic [7:0] FirstMask  = 8'h3f;
  localparam logic [7:0] MidMask    = 8'h7f;
  localparam logic [7:0] FinalMask  = 8'h0f;
  localparam int unsigned FinalShift = 27;

  // Byte position within one number
  localparam logic [PosW-1:0] PosFirst = 3'd0;
  localparam logic [PosW-1:0] PosFinal = 3'd4;

  // Result status codes
  localparam logic StatusOk      = 1'b0;
  localparam logic StatusEndOfBuf = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_last;
  } svd_item_t;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic            stalled;
  } svd_stat_t;

  // Shift of a middle byte's seven value bits: positions one to three
  function automatic logic [4:0] mid_shift(input logic [PosW-1:0] pos);
    logic [4:0] sh;
    case (pos)
      3'd1:    sh = 5'd6;
      3'd2:    sh = 5'd13;
      3'd3:    sh = 5'd20;
      default: sh = 5'd0;
    endcase
    return sh;
  endfunction

endpackage

>>> design/svd_if.sv
// Valid/ready channel interfaces for the signed varint decoder.
// Depends on svd_pkg for the value width.
interface svd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_last;

  modport source (output valid, output data_byte, output buffer_last, input ready);
  modport sink   (input valid, input data_byte, input buffer_last, output ready);
endinterface

interface svd_out_if
  import svd_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] decoded_value;
  logic                     status;

  modport source (output valid, output decoded_value, output status, input ready);
  modport sink   (input valid, input decoded_value, input status, output ready);
endinterface

>>> design/svd_in_reg.sv
// Input register of the signed varint decoder: holds one byte word.
// Depends on svd_pkg and svd_in_if.
module svd_in_reg
  import svd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  svd_in_if.sink     in_ch,
  output svd_item_t  item,
  output logic       item_vld,
  input  logic       item_take
);

  logic      in_vld_r;
  svd_item_t item_r;

  // Refill while empty, or when the held word leaves in the same cycle
  assign in_ch.ready = !in_vld_r || item_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r <= '{data_byte: in_ch.data_byte, buffer_last: in_ch.buffer_last};
    end
  end

  assign item     = item_r;
  assign item_vld = in_vld_r;

endmodule

>>> design/svd_step.sv
// Decode step of the signed varint decoder: number state and result register.
// Depends on svd_pkg and svd_out_if.
module svd_step
  import svd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  svd_item_t  item,
  input  logic       item_vld,
  output logic       item_take,
  svd_out_if.source  out_ch,
  output svd_stat_t  stat
);

  logic [ValueW-1:0] acc_r, acc_nxt;
  logic [PosW-1:0]   pos_r, pos_nxt;
  logic              neg_r, neg_nxt;

  logic              out_vld_r;
  logic [ValueW-1:0] out_val_r, res_val;
  logic              out_st_r, res_st;
  logic              emit;

  logic [ValueW-1:0] acc_v;
  logic              neg_v;
  logic              final_byte;

  assign item_take = item_vld && (!out_vld_r || out_ch.ready);

  always_comb begin
    acc_v      = acc_r;
    neg_v      = neg_r;
    final_byte = 1'b0;
    if (pos_r == PosFirst || pos_r > PosFinal) begin
      neg_v = item.data_byte[SignBit];
      acc_v = {{(ValueW-8){1'b0}}, item.data_byte & FirstMask};
    end else if (pos_r < PosFinal) begin
      acc_v = acc_r | ({{(ValueW-8){1'b0}}, item.data_byte & MidMask} << mid_shift(pos_r));
    end else begin
      acc_v      = acc_r | ({{(ValueW-8){1'b0}}, item.data_byte & FinalMask} << FinalShift);
      final_byte = 1'b1;
    end

    acc_nxt = acc_v;
    neg_nxt = neg_v;
    pos_nxt = (pos_r > PosFinal) ? 3'd1 : pos_r + 3'd1;
    emit    = 1'b0;
    res_val = neg_v ? ~acc_v : acc_v;
    res_st  = StatusOk;

    if (final_byte || !item.data_byte[ContBit]) begin
      emit = 1'b1;
    end else if (item.buffer_last) begin
      emit    = 1'b1;
      res_val = '0;
      res_st  = StatusEndOfBuf;
    end

    // Restart after every result
    if (emit) begin
      acc_nxt = '0;
      neg_nxt = 1'b0;
      pos_nxt = PosFirst;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      pos_r     <= PosFirst;
      neg_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (item_take) begin
      acc_r     <= acc_nxt;
      pos_r     <= pos_nxt;
      neg_r     <= neg_nxt;
      out_vld_r <= emit;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      out_val_r <= res_val;
      out_st_r  <= res_st;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.decoded_value = $signed(out_val_r);
  assign out_ch.status        = out_st_r;

  assign stat = '{pos: pos_r, stalled: out_vld_r && !out_ch.ready};

endmodule

>>> design/signed_varint_decoder.sv
// Top level of the signed varint decoder.
// Depends on svd_pkg, svd_if, svd_in_reg and svd_step.
//
// Decodes a stream of byte words into 32-bit signed integers, one byte word
// per cycle sustained while results are taken. The first byte of a number
// gives the sign in bit 6 and value bits [5:0]; bit 7 asks for another byte.
// Bytes two to four add seven bits each at shifts 6, 13 and 20; a fifth byte
// adds its low four bits at shift 27 and always ends the number. A finished
// number is inverted bitwise when its sign is set and leaves with status 0.
// A continuing byte marked buffer_last gives a result of value 0 with status
// 1 and restarts the decoder. Bytes inside a number give no result. A byte
// passes the input register and then the decode step, which writes the result
// register. Input and result registers part the two sides, so a new byte is
// taken while a result waits; in_ch.ready drops only when both registers are
// full and the result is not taken.
module signed_varint_decoder
  import svd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  svd_in_if.sink    in_ch,
  svd_out_if.source out_ch
);

  svd_item_t item;
  logic      item_vld;
  logic      item_take;
  svd_stat_t stat;

  // Hold the incoming byte word
  svd_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .item      (item),
    .item_vld  (item_vld),
    .item_take (item_take)
  );

  // Advance the number state and register the result
  svd_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .item_vld  (item_vld),
    .item_take (item_take),
    .out_ch    (out_ch),
    .stat      (stat)
  );

`ifndef SYNTHESIS
  // An end-of-buffer error always carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == StatusEndOfBuf |-> out_ch.decoded_value == '0)
    else $error("error word with non-zero value");

  // Byte position stays within a number
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pos <= PosFinal)
    else $error("byte position out of range");

  // A stalled result freezes the number state
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stat.stalled |-> !item_take)
    else $error("decode step advanced under a stalled result");
`endif

endmodule
